[rtl/impact_event_detector_core_macros.svh]
// assertion helpers shared by the rtl
`ifndef IMPACT_EVENT_DETECTOR_CORE_MACROS_SVH
`define IMPACT_EVENT_DETECTOR_CORE_MACROS_SVH

// same-cycle implication, disabled in reset
`define IED_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled in reset
`define IED_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/ied_pkg.sv]
`timescale 1ns / 1ps
package ied_pkg;

  // configuration register indexes
  localparam logic [2:0] CFG_CONTACT_THR = 3'd0;
  localparam logic [2:0] CFG_END_PCT     = 3'd1;
  localparam logic [2:0] CFG_HIGHG_THR   = 3'd2;
  localparam logic [2:0] CFG_LOWG_MG     = 3'd3;
  localparam logic [2:0] CFG_ACCEL_ONLY  = 3'd4;
  localparam logic [2:0] CFG_CONFIRM     = 3'd5;
  localparam logic [2:0] CFG_WINDOW_MS   = 3'd6;
  localparam logic [2:0] CFG_REFRACT_MS  = 3'd7;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // phase codes
  localparam logic [1:0] PH_IDLE    = 2'd0;
  localparam logic [1:0] PH_ACTIVE  = 2'd1;
  localparam logic [1:0] PH_REFRACT = 2'd2;

  localparam logic        CMD_SAMPLE = 1'b0;
  localparam logic        CMD_LOWG   = 1'b1;

  localparam int          MUL_W          = 32;
  localparam logic [31:0] RECIP100       = 32'd1374389535;
  localparam int          RECIP100_SHIFT = 37;
  localparam logic [31:0] US_PER_MS      = 32'd1000;
  localparam logic [31:0] QUIET_US       = 32'd30000;
  localparam logic [15:0] HIGHG_FLAG_MIN = 16'd4000;
  localparam logic [9:0]  TENTHS_MAX     = 10'd255;
  localparam int          EMA_SHIFT      = 6;
  localparam int          SQRT_STEPS     = 16;
  localparam logic [31:0] SQRT_BIT0      = 32'h4000_0000;
  localparam int          SPM_DEFAULT    = 1;

endpackage

[rtl/ied_if.sv]
`timescale 1ns / 1ps
interface ied_in_if;
  logic               valid;
  logic               ready;
  logic               command;
  logic [31:0]        time_us;
  logic [15:0]        force_a;
  logic [15:0]        force_b;
  logic signed [15:0] highg_x;
  logic signed [15:0] highg_y;
  logic signed [15:0] highg_z;
  logic signed [15:0] lowg_x;
  logic signed [15:0] lowg_y;
  logic signed [15:0] lowg_z;
  modport source (output valid, command, time_us, force_a, force_b, highg_x, highg_y,
                  highg_z, lowg_x, lowg_y, lowg_z, input ready);
  modport sink (input valid, command, time_us, force_a, force_b, highg_x, highg_y,
                highg_z, lowg_x, lowg_y, lowg_z, output ready);
endinterface

interface ied_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] event_time_us;
  logic [2:0]  event_flags;
  logic [7:0]  peak_lowg_tenths;
  logic [15:0] peak_highg;
  logic [15:0] peak_force_a;
  logic [15:0] peak_force_b;
  logic [15:0] contact_width_tenths;
  logic [31:0] impulse_sum;
  logic [31:0] event_sequence;
  logic [31:0] start_time_us;
  logic [15:0] retract_tenths;
  modport source (output valid, event_time_us, event_flags, peak_lowg_tenths, peak_highg,
                  peak_force_a, peak_force_b, contact_width_tenths, impulse_sum,
                  event_sequence, start_time_us, retract_tenths, input ready);
  modport sink (input valid, event_time_us, event_flags, peak_lowg_tenths, peak_highg,
                peak_force_a, peak_force_b, contact_width_tenths, impulse_sum,
                event_sequence, start_time_us, retract_tenths, output ready);
endinterface

interface ied_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [15:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[rtl/ied_mul.sv]
`timescale 1ns / 1ps
module ied_mul
  import ied_pkg::*;
(
  input  logic                 clk,
  input  logic [MUL_W-1:0]     a,
  input  logic [MUL_W-1:0]     b,
  output logic [2*MUL_W-1:0]   p
);
  logic [2*MUL_W-1:0] p_r;

  // product registered, usable in the cycle after issue
  always_ff @(posedge clk) begin
    p_r <= a * b;
  end

  assign p = p_r;
endmodule

[rtl/ied_isqrt.sv]
`timescale 1ns / 1ps
module ied_isqrt
  import ied_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] value,
  output logic        done,
  output logic [15:0] root
);
  localparam int CNT_W = $clog2(SQRT_STEPS);

  logic [31:0]      v_r, r_r, bit_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r, done_r;
  logic [32:0]      trial;

  assign trial = {1'b0, r_r} + {1'b0, bit_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(SQRT_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // one restoring step per cycle while busy
  always_ff @(posedge clk) begin
    if (start) begin
      v_r   <= value;
      r_r   <= '0;
      bit_r <= SQRT_BIT0;
    end else if (busy_r) begin
      if ({1'b0, v_r} >= trial) begin
        v_r <= v_r - trial[31:0];
        r_r <= (r_r >> 1) + bit_r;
      end else begin
        r_r <= r_r >> 1;
      end
      bit_r <= bit_r >> 2;
    end
  end

  assign done = done_r;
  assign root = r_r[15:0];
endmodule

[rtl/impact_event_detector_core.sv]
`timescale 1ns / 1ps
// impact event detector core
// in_ch carries words: command 0 is a high-rate sample (timestamp, two force
// counts, high-g xyz), command 1 refreshes the low-g vector energy only.
// cfg_ch writes one of eight registers by index; always ready, write only
// while the core is idle.
// out_ch delivers one event record word when an event closes.
// a sample that closes an event also runs the 16-step square root and three
// divides by 100; the products all run on one shared 32x32 multiplier and
// the root on one iterative root unit.
// in_ch.ready is high only while the sequencer is idle.
// the finished record sits in an output register; the core takes new words
// while it waits, and only stalls at its next emit if out_ch still holds
// an untaken record.
// reset (synchronous, active low) restores the register defaults, clears
// all tracking state and puts the phase machine in idle.
module impact_event_detector_core
  import ied_pkg::*;
#(
  parameter int SAMPLES_PER_MS = SPM_DEFAULT
)
(
  input  logic       clk,
  input  logic       rst_n,
  ied_in_if.sink     in_ch,
  ied_out_if.source  out_ch,
  ied_cfg_if.sink    cfg_ch
);
`include "impact_event_detector_core_macros.svh"

  // impulse divide by samples per ms through a reciprocal multiply
  localparam logic [31:0] SPM_RECIP = (SAMPLES_PER_MS <= 1) ? 32'd0 :
    32'(((64'd1 << 32) + 64'(SAMPLES_PER_MS) - 64'd1) / 64'(SAMPLES_PER_MS));

  // sequencer states
  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_LGX    = 5'd1;
  localparam logic [4:0] S_LGY    = 5'd2;
  localparam logic [4:0] S_LGZ    = 5'd3;
  localparam logic [4:0] S_LGW    = 5'd4;
  localparam logic [4:0] S_BASE   = 5'd5;
  localparam logic [4:0] S_HOLD   = 5'd6;
  localparam logic [4:0] S_HDIV   = 5'd7;
  localparam logic [4:0] S_IMP    = 5'd8;
  localparam logic [4:0] S_REFM   = 5'd9;
  localparam logic [4:0] S_WINM   = 5'd10;
  localparam logic [4:0] S_DECIDE = 5'd11;
  localparam logic [4:0] S_SQS    = 5'd12;
  localparam logic [4:0] S_SQW    = 5'd13;
  localparam logic [4:0] S_DLG    = 5'd14;
  localparam logic [4:0] S_DWID   = 5'd15;
  localparam logic [4:0] S_DRET   = 5'd16;
  localparam logic [4:0] S_EMIT   = 5'd17;

  logic [4:0] state_r;

  // configuration
  logic [15:0] thr_r, hs_thr_r, win_ms_r, refr_ms_r;
  logic [6:0]  pct_r;
  logic [14:0] lg_mg_r;
  logic        accel_only_r;
  logic [7:0]  confirm_r;

  // latched word
  logic [31:0] t_r;
  logic [15:0] fa_r, fb_r;
  logic [15:0] hx_r, hy_r, hz_r;
  logic [16:0] lx_r, ly_r, lz_r;

  // tracking state
  logic [1:0]  phase_r;
  logic        primed_r, in_contact_r, swing_seen_r;
  logic [15:0] base_a_r, base_b_r;
  logic [31:0] event_start_r, last_active_r, contact_begin_r, contact_finish_r;
  logic [15:0] max_highg_r, max_fa_r, max_fb_r;
  logic [31:0] impulse_r, seq_r, run_begin_r;
  logic [15:0] run_len_r;
  logic [31:0] lowg_energy_r, max_lowg_r;

  // per-word scratch
  logic [31:0] acc_r, refr_lim_r;
  logic [29:0] mgsq_r;
  logic [16:0] hold_q_r, imp_q_r;
  logic [9:0]  lg_q_r;
  logic [25:0] wid_q_r, retr_q_r;

  // output register
  logic        out_valid_r;
  logic [31:0] o_time_r, o_imp_r, o_seq_r, o_start_r;
  logic [2:0]  o_flags_r;
  logic [7:0]  o_lg_r;
  logic [15:0] o_hg_r, o_fa_r, o_fb_r, o_wid_r, o_retr_r;

  // shared units
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;
  logic        sq_start, sq_done;
  logic [15:0] sq_root;

  ied_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p(mul_p));

  ied_isqrt u_sqrt (
    .clk(clk), .rst_n(rst_n), .start(sq_start), .value(max_lowg_r),
    .done(sq_done), .root(sq_root)
  );

  function automatic logic [16:0] abs16(input logic [15:0] v);
    abs16 = v[15] ? (17'h10000 - {1'b0, v}) : {1'b0, v};
  endfunction

  // ema step, divide by 64 truncating toward zero
  function automatic logic [15:0] ema(input logic [15:0] base, input logic [15:0] f);
    logic [16:0] dif, mag, q;
    dif = {1'b0, f} - {1'b0, base};
    mag = dif[16] ? (17'd0 - dif) : dif;
    q   = mag >> EMA_SHIFT;
    ema = dif[16] ? (base - q[15:0]) : (base + q[15:0]);
  endfunction

  function automatic logic [15:0] sat16(input logic [25:0] v);
    sat16 = (v > 26'd65535) ? 16'hFFFF : v[15:0];
  endfunction

  // combinational view of the current sample
  logic [16:0] ax, ay, az, hi, lo;
  logic [15:0] mag, ra, rb, pk, need, rl1;
  logic [16:0] hold_eff, sum_ab;
  logic        pressed, touch_hit, swing, open_hit, live_hit;
  logic [15:0] base_a_nxt, base_b_nxt, b0a, b0b;
  logic [31:0] win_lim;

  always_comb begin
    ax = {1'b0, hx_r};
    ay = {1'b0, hy_r};
    az = {1'b0, hz_r};
    ax = abs16(hx_r);
    ay = abs16(hy_r);
    az = abs16(hz_r);
    hi = ax;
    lo = ax;
    if (ay > hi) hi = ay;
    if (az > hi) hi = az;
    if (ay < lo) lo = ay;
    if (az < lo) lo = az;
  end

  assign mag    = 16'(hi + (lo >> 1));
  assign ra     = (fa_r > base_a_r) ? (fa_r - base_a_r) : 16'd0;
  assign rb     = (fb_r > base_b_r) ? (fb_r - base_b_r) : 16'd0;
  assign sum_ab = {1'b0, ra} + {1'b0, rb};
  assign pk     = (max_fa_r > max_fb_r) ? max_fa_r : max_fb_r;
  assign pressed = (ra > thr_r) || (rb > thr_r);
  assign hold_eff = (hold_q_r < {1'b0, thr_r}) ? {1'b0, thr_r} : hold_q_r;
  // hold threshold from the event peak once contact is established
  assign touch_hit = (pressed && phase_r == PH_ACTIVE && in_contact_r && pct_r != 7'd0)
                     ? (({1'b0, ra} > hold_eff) || ({1'b0, rb} > hold_eff)) : pressed;
  assign swing = (mag > hs_thr_r) ||
                 (lg_mg_r != 15'd0 && lowg_energy_r > {2'b00, mgsq_r});
  assign open_hit   = accel_only_r ? swing : (swing || touch_hit);
  assign live_hit   = swing || touch_hit;
  assign need       = swing ? 16'd1 : {8'd0, confirm_r};
  assign rl1        = run_len_r + 16'd1;
  assign win_lim    = mul_p[31:0];

  // baseline: seed on first sample, frozen while active
  assign b0a = primed_r ? base_a_r : fa_r;
  assign b0b = primed_r ? base_b_r : fb_r;
  assign base_a_nxt = (phase_r != PH_ACTIVE) ? ema(b0a, fa_r) : b0a;
  assign base_b_nxt = (phase_r != PH_ACTIVE) ? ema(b0b, fb_r) : b0b;

  // phase machine decision
  logic [1:0]  phase_nxt;
  logic        ic_nxt, ss_nxt, emit, upd;
  logic [31:0] es_nxt, la_nxt, cb_nxt, cf_nxt, imp_nxt, seq_nxt, rb_nxt, mle_nxt;
  logic [15:0] mh_nxt, mfa_nxt, mfb_nxt, rl_nxt;

  always_comb begin
    phase_nxt = phase_r;
    ic_nxt    = in_contact_r;
    ss_nxt    = swing_seen_r;
    es_nxt    = event_start_r;
    la_nxt    = last_active_r;
    cb_nxt    = contact_begin_r;
    cf_nxt    = contact_finish_r;
    imp_nxt   = impulse_r;
    seq_nxt   = seq_r;
    rb_nxt    = run_begin_r;
    mle_nxt   = max_lowg_r;
    mh_nxt    = max_highg_r;
    mfa_nxt   = max_fa_r;
    mfb_nxt   = max_fb_r;
    rl_nxt    = run_len_r;
    emit      = 1'b0;
    upd       = 1'b0;
    if (phase_r == PH_REFRACT) begin
      if ((t_r - last_active_r) > refr_lim_r) phase_nxt = PH_IDLE;
    end else if (phase_r == PH_ACTIVE) begin
      upd = 1'b1;
    end else if (!open_hit) begin
      // idle, and the unused phase code acts as idle
      rl_nxt = '0;
    end else begin
      if (run_len_r == 16'd0) rb_nxt = t_r;
      if (rl1 < need) begin
        rl_nxt = rl1;
      end else begin
        // open a new event
        rl_nxt    = '0;
        mh_nxt    = '0;
        mfa_nxt   = '0;
        mfb_nxt   = '0;
        imp_nxt   = '0;
        ic_nxt    = 1'b0;
        cb_nxt    = '0;
        cf_nxt    = '0;
        mle_nxt   = '0;
        ss_nxt    = 1'b0;
        phase_nxt = PH_ACTIVE;
        es_nxt    = rb_nxt;
        la_nxt    = t_r;
        upd       = 1'b1;
      end
    end
    if (upd) begin
      if (mag > mh_nxt) mh_nxt = mag;
      if (lowg_energy_r > mle_nxt) mle_nxt = lowg_energy_r;
      if (swing) ss_nxt = 1'b1;
      if (ra > mfa_nxt) mfa_nxt = ra;
      if (rb > mfb_nxt) mfb_nxt = rb;
      if (touch_hit) begin
        if (!ic_nxt) begin
          ic_nxt = 1'b1;
          cb_nxt = t_r;
        end
        cf_nxt = t_r;
      end
      if (pressed) imp_nxt = imp_nxt + {15'd0, imp_q_r};
      if (live_hit) la_nxt = t_r;
      // close on quiet time or window expiry
      if ((t_r - la_nxt) > QUIET_US || (t_r - es_nxt) > win_lim) begin
        emit      = 1'b1;
        seq_nxt   = seq_r + 32'd1;
        phase_nxt = PH_REFRACT;
        la_nxt    = t_r;
      end
    end
  end

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      S_LGX: begin
        mul_a = {15'd0, lx_r};
        mul_b = {15'd0, lx_r};
      end
      S_LGY: begin
        mul_a = {15'd0, ly_r};
        mul_b = {15'd0, ly_r};
      end
      S_LGZ: begin
        mul_a = {15'd0, lz_r};
        mul_b = {15'd0, lz_r};
      end
      S_BASE: begin
        mul_a = {17'd0, lg_mg_r};
        mul_b = {17'd0, lg_mg_r};
      end
      S_HOLD: begin
        mul_a = {16'd0, pk};
        mul_b = {25'd0, pct_r};
      end
      S_HDIV: begin
        mul_a = mul_p[31:0];
        mul_b = RECIP100;
      end
      S_IMP: begin
        mul_a = {15'd0, sum_ab};
        mul_b = SPM_RECIP;
      end
      S_REFM: begin
        mul_a = {16'd0, refr_ms_r};
        mul_b = US_PER_MS;
      end
      S_WINM: begin
        mul_a = {16'd0, win_ms_r};
        mul_b = US_PER_MS;
      end
      S_SQW: begin
        mul_a = {16'd0, sq_root};
        mul_b = RECIP100;
      end
      S_DLG: begin
        mul_a = contact_finish_r - contact_begin_r;
        mul_b = RECIP100;
      end
      S_DWID: begin
        mul_a = t_r - contact_finish_r;
        mul_b = RECIP100;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign sq_start = (state_r == S_SQS);

  logic in_acc, out_load;
  assign in_ch.ready = (state_r == S_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign out_load    = (state_r == S_EMIT) && (!out_valid_r || out_ch.ready);
  assign cfg_ch.ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r        <= 16'd200;
      pct_r        <= 7'd30;
      hs_thr_r     <= 16'd100;
      lg_mg_r      <= 15'd3000;
      accel_only_r <= 1'b1;
      confirm_r    <= 8'd3;
      win_ms_r     <= 16'd400;
      refr_ms_r    <= 16'd150;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        CFG_CONTACT_THR: thr_r        <= cfg_ch.data;
        CFG_END_PCT:     pct_r        <= cfg_ch.data[6:0];
        CFG_HIGHG_THR:   hs_thr_r     <= cfg_ch.data;
        CFG_LOWG_MG:     lg_mg_r      <= cfg_ch.data[14:0];
        CFG_ACCEL_ONLY:  accel_only_r <= cfg_ch.data[0];
        CFG_CONFIRM:     confirm_r    <= cfg_ch.data[7:0];
        CFG_WINDOW_MS:   win_ms_r     <= cfg_ch.data;
        CFG_REFRACT_MS:  refr_ms_r    <= cfg_ch.data;
        default: begin
        end
      endcase
    end
  end

  // sequencer and tracking state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r          <= S_IDLE;
      phase_r          <= PH_IDLE;
      primed_r         <= 1'b0;
      in_contact_r     <= 1'b0;
      swing_seen_r     <= 1'b0;
      base_a_r         <= '0;
      base_b_r         <= '0;
      event_start_r    <= '0;
      last_active_r    <= '0;
      contact_begin_r  <= '0;
      contact_finish_r <= '0;
      max_highg_r      <= '0;
      max_fa_r         <= '0;
      max_fb_r         <= '0;
      impulse_r        <= '0;
      seq_r            <= '0;
      run_len_r        <= '0;
      run_begin_r      <= '0;
      lowg_energy_r    <= '0;
      max_lowg_r       <= '0;
      out_valid_r      <= 1'b0;
    end else begin
      // record held until taken, reloaded only from the emit state
      if (out_load) out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (in_acc) state_r <= (in_ch.command == CMD_LOWG) ? S_LGX : S_BASE;
        end
        S_LGX:  state_r <= S_LGY;
        S_LGY:  state_r <= S_LGZ;
        S_LGZ:  state_r <= S_LGW;
        S_LGW: begin
          lowg_energy_r <= acc_r + mul_p[31:0];
          state_r       <= S_IDLE;
        end
        S_BASE: begin
          base_a_r <= base_a_nxt;
          base_b_r <= base_b_nxt;
          primed_r <= 1'b1;
          state_r  <= S_HOLD;
        end
        S_HOLD: state_r <= S_HDIV;
        S_HDIV: state_r <= S_IMP;
        S_IMP:  state_r <= S_REFM;
        S_REFM: state_r <= S_WINM;
        S_WINM: state_r <= S_DECIDE;
        S_DECIDE: begin
          phase_r          <= phase_nxt;
          in_contact_r     <= ic_nxt;
          swing_seen_r     <= ss_nxt;
          event_start_r    <= es_nxt;
          last_active_r    <= la_nxt;
          contact_begin_r  <= cb_nxt;
          contact_finish_r <= cf_nxt;
          impulse_r        <= imp_nxt;
          seq_r            <= seq_nxt;
          run_begin_r      <= rb_nxt;
          max_lowg_r       <= mle_nxt;
          max_highg_r      <= mh_nxt;
          max_fa_r         <= mfa_nxt;
          max_fb_r         <= mfb_nxt;
          run_len_r        <= rl_nxt;
          state_r          <= emit ? S_SQS : S_IDLE;
        end
        S_SQS:  state_r <= S_SQW;
        S_SQW: begin
          if (sq_done) state_r <= S_DLG;
        end
        S_DLG:  state_r <= S_DWID;
        S_DWID: state_r <= S_DRET;
        S_DRET: state_r <= S_EMIT;
        S_EMIT: begin
          if (out_load) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // payload and scratch registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      t_r  <= in_ch.time_us;
      fa_r <= in_ch.force_a;
      fb_r <= in_ch.force_b;
      hx_r <= in_ch.highg_x;
      hy_r <= in_ch.highg_y;
      hz_r <= in_ch.highg_z;
      lx_r <= abs16(in_ch.lowg_x);
      ly_r <= abs16(in_ch.lowg_y);
      lz_r <= abs16(in_ch.lowg_z);
    end
    case (state_r)
      S_LGY:  acc_r      <= mul_p[31:0];
      S_LGZ:  acc_r      <= acc_r + mul_p[31:0];
      S_HOLD: mgsq_r     <= mul_p[29:0];
      S_IMP:  hold_q_r   <= mul_p[RECIP100_SHIFT+16:RECIP100_SHIFT];
      S_REFM: imp_q_r    <= (SAMPLES_PER_MS <= 1) ? sum_ab : mul_p[48:32];
      S_WINM: refr_lim_r <= mul_p[31:0];
      S_DLG:  lg_q_r     <= mul_p[RECIP100_SHIFT+9:RECIP100_SHIFT];
      S_DWID: wid_q_r    <= mul_p[RECIP100_SHIFT+25:RECIP100_SHIFT];
      S_DRET: retr_q_r   <= mul_p[RECIP100_SHIFT+25:RECIP100_SHIFT];
      default: begin
      end
    endcase
    if (out_load) begin
      o_time_r  <= in_contact_r ? contact_begin_r : event_start_r;
      o_flags_r <= {swing_seen_r, (max_highg_r >= HIGHG_FLAG_MIN), in_contact_r};
      o_lg_r    <= (lg_q_r > TENTHS_MAX) ? TENTHS_MAX[7:0] : lg_q_r[7:0];
      o_hg_r    <= max_highg_r;
      o_fa_r    <= max_fa_r;
      o_fb_r    <= max_fb_r;
      o_wid_r   <= in_contact_r ? sat16(wid_q_r) : 16'd0;
      o_imp_r   <= impulse_r;
      o_seq_r   <= seq_r;
      o_start_r <= event_start_r;
      o_retr_r  <= in_contact_r ? sat16(retr_q_r) : 16'd0;
    end
  end

  assign out_ch.valid                = out_valid_r;
  assign out_ch.event_time_us        = o_time_r;
  assign out_ch.event_flags          = o_flags_r;
  assign out_ch.peak_lowg_tenths     = o_lg_r;
  assign out_ch.peak_highg           = o_hg_r;
  assign out_ch.peak_force_a         = o_fa_r;
  assign out_ch.peak_force_b         = o_fb_r;
  assign out_ch.contact_width_tenths = o_wid_r;
  assign out_ch.impulse_sum          = o_imp_r;
  assign out_ch.event_sequence       = o_seq_r;
  assign out_ch.start_time_us        = o_start_r;
  assign out_ch.retract_tenths       = o_retr_r;

  // event counter moves only on a decision
  `IED_ASSERT_NXT(a_seq_only_decide, clk, rst_n, state_r != S_DECIDE, $stable(seq_r), "seq moved")
  // a loaded record is presented next cycle
  `IED_ASSERT_NXT(a_emit_loads, clk, rst_n, out_load, out_valid_r, "record not presented")
  // root unit finishes only while the sequencer waits on it
  `IED_ASSERT_IMP(a_sqrt_owned, clk, rst_n, sq_done, state_r == S_SQW, "stray root done")

endmodule

[sim/ied_scoreboard.sv]
`timescale 1ns / 1ps
// watches the three channels, predicts event records and checks them
module ied_scoreboard
  import ied_pkg::*;
#(
  parameter int SAMPLES_PER_MS = SPM_DEFAULT
)
(
  input  logic clk,
  input  logic rst_n,
  ied_in_if    in_mon,
  ied_out_if   out_mon,
  ied_cfg_if   cfg_mon,
  output int   errors,
  output int   pending
);

  typedef struct packed {
    logic [31:0] event_time_us;
    logic [2:0]  event_flags;
    logic [7:0]  peak_lowg_tenths;
    logic [15:0] peak_highg;
    logic [15:0] peak_force_a;
    logic [15:0] peak_force_b;
    logic [15:0] contact_width_tenths;
    logic [31:0] impulse_sum;
    logic [31:0] event_sequence;
    logic [31:0] start_time_us;
    logic [15:0] retract_tenths;
  } event_rec_t;

  event_rec_t event_q[$];

  // register copies
  logic [15:0] thr, hg_thr, win_ms, refr_ms;
  logic [6:0]  end_pct;
  logic [14:0] lg_mg;
  logic        accel_only;
  logic [7:0]  confirm;

  // detector state
  logic [1:0]  ph;
  logic        primed, in_ct, swing_seen;
  logic [15:0] base_a, base_b, pk_hg, pk_fa, pk_fb, run_len;
  logic [31:0] ev_start, last_act, ct_begin, ct_finish;
  logic [31:0] imp, seq, run_begin, lowg_e, pk_lowg_e;

  function automatic logic [31:0] magnitude(logic [15:0] v);
    return v[15] ? 32'h10000 - 32'(v) : 32'(v);
  endfunction

  function automatic logic [31:0] isqrt(logic [31:0] v);
    logic [31:0] r, b;
    r = 0;
    b = SQRT_BIT0;
    for (int i = 0; i < SQRT_STEPS; i++) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic [15:0] ema(logic [15:0] b, logic [15:0] f);
    int d;
    d = (int'(32'(f)) - int'(32'(b))) / 64;
    return 16'(int'(32'(b)) + d);
  endfunction

  function automatic logic [15:0] sat16(logic [31:0] v);
    return v > 32'd65535 ? 16'hFFFF : v[15:0];
  endfunction

  // one high-rate sample; returns 1 when an event record closes
  function automatic bit take_sample(input logic [31:0] t, input logic [15:0] fa, fb,
                                     input logic [15:0] hx, hy, hz, output event_rec_t r);
    logic [31:0] ax, ay, az, hi, lo, mag, ra, rb, pk, hold, lg;
    bit pressed, ct_now, swing, open_hit, act_now;
    r = '0;
    ax = magnitude(hx);
    ay = magnitude(hy);
    az = magnitude(hz);
    hi = ax;
    lo = ax;
    if (ay > hi) hi = ay;
    if (az > hi) hi = az;
    if (ay < lo) lo = ay;
    if (az < lo) lo = az;
    mag = hi + lo / 2;
    if (!primed) begin
      base_a = fa;
      base_b = fb;
      primed = 1;
    end
    if (ph != PH_ACTIVE) begin
      base_a = ema(base_a, fa);
      base_b = ema(base_b, fb);
    end
    ra = fa > base_a ? 32'(fa - base_a) : 0;
    rb = fb > base_b ? 32'(fb - base_b) : 0;
    pressed = ra > thr || rb > thr;
    ct_now = pressed;
    // release hysteresis: contact holds above a fraction of the peak
    if (pressed && ph == PH_ACTIVE && in_ct && end_pct != 0) begin
      pk = pk_fa > pk_fb ? 32'(pk_fa) : 32'(pk_fb);
      hold = pk * 32'(end_pct) / 100;
      if (hold < thr) hold = 32'(thr);
      ct_now = ra > hold || rb > hold;
    end
    swing = mag > hg_thr || (lg_mg != 0 && lowg_e > 32'(lg_mg) * 32'(lg_mg));
    open_hit = accel_only ? swing : (swing || ct_now);
    act_now = swing || ct_now;

    if (ph == PH_REFRACT) begin
      if (32'(t - last_act) > 32'(refr_ms) * 32'd1000) ph = PH_IDLE;
      return 0;
    end
    if (ph != PH_ACTIVE) begin
      if (!open_hit) begin
        run_len = 0;
        return 0;
      end
      if (run_len == 0) run_begin = t;
      run_len++;
      if (32'(run_len) < (swing ? 32'd1 : 32'(confirm))) return 0;
      run_len = 0;
      pk_hg = 0;
      pk_fa = 0;
      pk_fb = 0;
      imp = 0;
      in_ct = 0;
      ct_begin = 0;
      ct_finish = 0;
      pk_lowg_e = 0;
      swing_seen = 0;
      ph = PH_ACTIVE;
      ev_start = run_begin;
      last_act = t;
    end

    if (mag > pk_hg) pk_hg = mag[15:0];
    if (lowg_e > pk_lowg_e) pk_lowg_e = lowg_e;
    if (swing) swing_seen = 1;
    if (ra > pk_fa) pk_fa = ra[15:0];
    if (rb > pk_fb) pk_fb = rb[15:0];
    if (ct_now) begin
      if (!in_ct) begin
        in_ct = 1;
        ct_begin = t;
      end
      ct_finish = t;
    end
    if (pressed) imp = imp + (ra + rb) / SAMPLES_PER_MS;
    if (act_now) last_act = t;

    if (32'(t - last_act) > QUIET_US || 32'(t - ev_start) > 32'(win_ms) * 32'd1000) begin
      lg = isqrt(pk_lowg_e) / 100;
      seq++;
      r.event_time_us = in_ct ? ct_begin : ev_start;
      r.event_flags = {swing_seen, pk_hg >= HIGHG_FLAG_MIN, in_ct};
      r.peak_lowg_tenths = lg > 255 ? 8'hFF : lg[7:0];
      r.peak_highg = pk_hg;
      r.peak_force_a = pk_fa;
      r.peak_force_b = pk_fb;
      r.contact_width_tenths = in_ct ? sat16(32'(ct_finish - ct_begin) / 100) : 0;
      r.impulse_sum = imp;
      r.event_sequence = seq;
      r.start_time_us = ev_start;
      r.retract_tenths = in_ct ? sat16(32'(t - ct_finish) / 100) : 0;
      ph = PH_REFRACT;
      last_act = t;
      return 1;
    end
    return 0;
  endfunction

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("%0t mismatch %s: got %0h want %0h", $time, what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    event_rec_t rec, seen;
    int x, y, z;
    if (!rst_n) begin
      event_q.delete();
      errors = 0;
      thr = 200; end_pct = 30; hg_thr = 100; lg_mg = 3000;
      accel_only = 1; confirm = 3; win_ms = 400; refr_ms = 150;
      ph = PH_IDLE; primed = 0; in_ct = 0; swing_seen = 0;
      base_a = 0; base_b = 0; pk_hg = 0; pk_fa = 0; pk_fb = 0; run_len = 0;
      ev_start = 0; last_act = 0; ct_begin = 0; ct_finish = 0;
      imp = 0; seq = 0; run_begin = 0; lowg_e = 0; pk_lowg_e = 0;
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_mon.index)
          CFG_CONTACT_THR: thr = cfg_mon.data;
          CFG_END_PCT:     end_pct = cfg_mon.data[6:0];
          CFG_HIGHG_THR:   hg_thr = cfg_mon.data;
          CFG_LOWG_MG:     lg_mg = cfg_mon.data[14:0];
          CFG_ACCEL_ONLY:  accel_only = cfg_mon.data[0];
          CFG_CONFIRM:     confirm = cfg_mon.data[7:0];
          CFG_WINDOW_MS:   win_ms = cfg_mon.data;
          CFG_REFRACT_MS:  refr_ms = cfg_mon.data;
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready) begin
        if (in_mon.command == CMD_LOWG) begin
          // squared magnitude, wrapping in 32 bits
          x = int'(in_mon.lowg_x);
          y = int'(in_mon.lowg_y);
          z = int'(in_mon.lowg_z);
          lowg_e = 32'(x * x) + 32'(y * y) + 32'(z * z);
        end else if (take_sample(in_mon.time_us, in_mon.force_a, in_mon.force_b,
                                 in_mon.highg_x, in_mon.highg_y, in_mon.highg_z, rec)) begin
          event_q.push_back(rec);
        end
      end
      if (out_mon.valid && out_mon.ready) begin
        if (event_q.size() == 0) begin
          report("unexpected record seq", out_mon.event_sequence, 0);
        end else begin
          seen = event_q.pop_front();
          if (out_mon.event_time_us !== seen.event_time_us)
            report("event_time_us", out_mon.event_time_us, seen.event_time_us);
          if (out_mon.event_flags !== seen.event_flags)
            report("event_flags", out_mon.event_flags, seen.event_flags);
          if (out_mon.peak_lowg_tenths !== seen.peak_lowg_tenths)
            report("peak_lowg_tenths", out_mon.peak_lowg_tenths, seen.peak_lowg_tenths);
          if (out_mon.peak_highg !== seen.peak_highg)
            report("peak_highg", out_mon.peak_highg, seen.peak_highg);
          if (out_mon.peak_force_a !== seen.peak_force_a)
            report("peak_force_a", out_mon.peak_force_a, seen.peak_force_a);
          if (out_mon.peak_force_b !== seen.peak_force_b)
            report("peak_force_b", out_mon.peak_force_b, seen.peak_force_b);
          if (out_mon.contact_width_tenths !== seen.contact_width_tenths)
            report("contact_width_tenths", out_mon.contact_width_tenths,
                   seen.contact_width_tenths);
          if (out_mon.impulse_sum !== seen.impulse_sum)
            report("impulse_sum", out_mon.impulse_sum, seen.impulse_sum);
          if (out_mon.event_sequence !== seen.event_sequence)
            report("event_sequence", out_mon.event_sequence, seen.event_sequence);
          if (out_mon.start_time_us !== seen.start_time_us)
            report("start_time_us", out_mon.start_time_us, seen.start_time_us);
          if (out_mon.retract_tenths !== seen.retract_tenths)
            report("retract_tenths", out_mon.retract_tenths, seen.retract_tenths);
        end
      end
    end
    pending = event_q.size();
  end

endmodule

[sim/tb.sv]
`timescale 1ns / 1ps
module tb;
  import ied_pkg::*;

  // cycles with no word moving on any channel before giving up
  localparam int STALL_LIMIT = 20000;
  // cycles the sink holds off in the pressure test
  localparam int HOLDOFF_CYCLES = 3000;

  typedef enum {K_QUIET, K_PRESS, K_SWING, K_NOISE} sample_kind_t;

  logic clk;
  logic rst_n;

  ied_in_if  in_ch();
  ied_out_if out_ch();
  ied_cfg_if cfg_ch();

  impact_event_detector_core dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  int errors;
  int pending;

  ied_scoreboard checker_u (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_mon  (in_ch),
    .out_mon (out_ch),
    .cfg_mon (cfg_ch),
    .errors  (errors),
    .pending (pending)
  );

  // stimulus state
  logic [31:0] now_us;
  logic [15:0] rest_a, rest_b;
  bit          calm;       // no idling on either side while set
  bit          hold_req;   // asks the sink for one long hold-off
  int          stall;

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  // watchdog: counts cycles in which nothing is accepted
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready) || !rst_n) begin
      stall <= 0;
    end else if (stall >= STALL_LIMIT) begin
      $display("[impact_event_detector_core] ERROR");
      $finish;
    end else begin
      stall <= stall + 1;
    end
  end

  // result sink: random stalls, one long hold-off on request
  initial begin
    out_ch.ready <= 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ch.ready <= 0;
        repeat (HOLDOFF_CYCLES) @(posedge clk);
        hold_req = 0;
      end else begin
        out_ch.ready <= calm || ($urandom_range(99) >= 30);
      end
    end
  end

  // one word on in_ch, then maybe an idle gap
  task automatic send_word(input logic cmd, input logic [31:0] t,
                           input logic [15:0] fa, input logic [15:0] fb,
                           input logic [15:0] hx, input logic [15:0] hy, input logic [15:0] hz,
                           input logic [15:0] lx, input logic [15:0] ly, input logic [15:0] lz);
    in_ch.valid   <= 1;
    in_ch.command <= cmd;
    in_ch.time_us <= t;
    in_ch.force_a <= fa;
    in_ch.force_b <= fb;
    in_ch.highg_x <= hx;
    in_ch.highg_y <= hy;
    in_ch.highg_z <= hz;
    in_ch.lowg_x  <= lx;
    in_ch.lowg_y  <= ly;
    in_ch.lowg_z  <= lz;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    if (!calm && $urandom_range(99) < 30) begin
      in_ch.valid <= 0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
    cfg_ch.valid <= 1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 0;
    @(posedge clk);
  endtask

  // drain, let a possible trailing close settle, then load all registers
  task automatic load_setting(input logic [15:0] thr, input logic [15:0] pct,
                              input logic [15:0] hg, input logic [15:0] lg,
                              input logic [15:0] accel, input logic [15:0] conf,
                              input logic [15:0] win, input logic [15:0] refr);
    in_ch.valid <= 0;
    while (pending != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    write_reg(CFG_CONTACT_THR, thr);
    write_reg(CFG_END_PCT, pct);
    write_reg(CFG_HIGHG_THR, hg);
    write_reg(CFG_LOWG_MG, lg);
    write_reg(CFG_ACCEL_ONLY, accel);
    write_reg(CFG_CONFIRM, conf);
    write_reg(CFG_WINDOW_MS, win);
    write_reg(CFG_REFRACT_MS, refr);
    rest_a = 16'($urandom_range(50, 3000));
    rest_b = 16'($urandom_range(50, 3000));
  endtask

  // one high-rate sample; time mostly steps by about a millisecond
  task automatic sample(input sample_kind_t kind);
    logic [31:0] dt;
    logic [15:0] fa, fb, hx, hy, hz;
    int r;
    r = $urandom_range(99);
    if (r < 75)      dt = 32'($urandom_range(900, 1100));
    else if (r < 92) dt = 32'($urandom_range(60000));
    else if (r < 96) dt = 0;
    else             dt = $urandom();
    now_us = now_us + dt;
    fa = rest_a + 16'($urandom_range(40));
    fb = rest_b + 16'($urandom_range(40));
    hx = 16'($urandom_range(60)) - 16'd30;
    hy = 16'($urandom_range(60)) - 16'd30;
    hz = 16'($urandom_range(60)) - 16'd30;
    case (kind)
      K_PRESS: begin
        fa = fa + 16'($urandom_range(8000));
        if ($urandom_range(1)) fb = fb + 16'($urandom_range(8000));
      end
      K_SWING: begin
        hx = 16'($urandom());
        hy = 16'($urandom_range(6000)) - 16'd3000;
        if ($urandom_range(1)) hz = 16'($urandom());
      end
      K_NOISE: begin
        fa = 16'($urandom());
        fb = 16'($urandom());
        hx = 16'($urandom());
        hy = 16'($urandom());
        hz = 16'($urandom());
      end
      default: ;
    endcase
    send_word(CMD_SAMPLE, now_us, fa, fb, hx, hy, hz, 16'($urandom()), 16'($urandom()),
              16'($urandom()));
  endtask

  // low-g update, usually small, sometimes a swing-sized vector
  task automatic lowg_update(input bit big);
    logic [15:0] span;
    span = big ? 16'd32767 : 16'd1500;
    send_word(CMD_LOWG, $urandom(), 16'($urandom()), 16'($urandom()), 16'($urandom()),
              16'($urandom()), 16'($urandom()),
              16'($urandom_range(2 * span)) - span, 16'($urandom_range(2 * span)) - span,
              16'($urandom_range(2 * span)) - span);
  endtask

  // well-formed episodes: quiet stretches, presses, swings, with some noise
  task automatic random_words(input int count);
    int done, len, pick;
    sample_kind_t kind;
    done = 0;
    while (done < count) begin
      pick = $urandom_range(99);
      if (pick < 8) begin
        lowg_update($urandom_range(99) < 35);
        done++;
      end else begin
        if (pick < 50)      begin kind = K_QUIET; len = $urandom_range(5, 40); end
        else if (pick < 72) begin kind = K_PRESS; len = $urandom_range(1, 8); end
        else if (pick < 93) begin kind = K_SWING; len = $urandom_range(1, 4); end
        else                begin kind = K_NOISE; len = $urandom_range(1, 2); end
        repeat (len) sample(kind);
        done += len;
      end
    end
  endtask

  initial begin
    rst_n         <= 0;
    calm          = 0;
    hold_req      = 0;
    now_us        = 32'hFFFF_F000;
    rest_a        = 16'd1000;
    rest_b        = 16'd800;
    in_ch.valid   <= 0;
    in_ch.command <= CMD_SAMPLE;
    in_ch.time_us <= 0;
    in_ch.force_a <= 0;
    in_ch.force_b <= 0;
    in_ch.highg_x <= 0;
    in_ch.highg_y <= 0;
    in_ch.highg_z <= 0;
    in_ch.lowg_x  <= 0;
    in_ch.lowg_y  <= 0;
    in_ch.lowg_z  <= 0;
    cfg_ch.valid  <= 0;
    cfg_ch.index  <= CFG_CONTACT_THR;
    cfg_ch.data   <= 0;
    repeat (11) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed part under reset defaults
    // first sample seeds the baselines at the force extremes
    send_word(CMD_SAMPLE, now_us, 16'hFFFF, 16'h0000, 16'h8000, 16'h7FFF, 16'h0000,
              0, 0, 0);
    // lowg extremes: the most negative vector gives the largest energy sum
    send_word(CMD_LOWG, 0, 0, 0, 0, 0, 0, 16'h8000, 16'h8000, 16'h8000);
    send_word(CMD_LOWG, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
              16'h7FFF, 16'h7FFF, 16'h7FFF);
    // swing open across the timestamp wrap, repeated timestamp
    now_us = now_us + 32'd1000;
    send_word(CMD_SAMPLE, now_us, 16'hFFFF, 16'h0000, 16'h8000, 16'h8000, 16'h8000,
              0, 0, 0);
    send_word(CMD_SAMPLE, now_us, 16'h0000, 16'hFFFF, 16'h7FFF, 16'h7FFF, 16'h7FFF,
              0, 0, 0);
    send_word(CMD_LOWG, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    now_us = 32'h0000_0800;
    repeat (4) sample(K_PRESS);
    // quiet past 30 ms closes the event
    repeat (3) sample(K_QUIET);
    now_us = now_us + 32'd40000;
    sample(K_QUIET);
    // refractory expires after a long gap, then a fresh swing
    now_us = now_us + 32'd200000;
    sample(K_QUIET);
    sample(K_SWING);
    sample(K_PRESS);
    now_us = now_us + 32'd500000;
    sample(K_QUIET);
    sample(K_NOISE);
    sample(K_NOISE);

    random_words(230);

    // everything opens, shortest nonzero window, zero confirmation, no refractory
    load_setting(16'd0, 16'd0, 16'hFFFF, 16'd0, 16'd0, 16'd0, 16'd1, 16'd0);
    random_words(250);

    // top extremes, percent above 100, very long refractory
    load_setting(16'hFFFF, 16'd127, 16'd100, 16'h7FFF, 16'd0, 16'd255, 16'hFFFF, 16'hFFFF);
    random_words(150);

    // contact-driven setting with short windows; pressure tests here
    load_setting(16'd300, 16'd100, 16'd2000, 16'd1500, 16'd0, 16'd2, 16'd50, 16'd20);
    random_words(120);
    // sink holds off while words keep coming, so the core fills and stalls
    hold_req = 1;
    random_words(120);
    // sender waits for every record before going on
    in_ch.valid <= 0;
    while (pending != 0) @(posedge clk);
    random_words(110);

    // back near defaults, with a long stretch without idling
    load_setting(16'd150, 16'd50, 16'd500, 16'd3000, 16'd1, 16'd3, 16'd400, 16'd150);
    calm = 1;
    random_words(150);
    calm = 0;
    random_words(200);

    in_ch.valid <= 0;
    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("[impact_event_detector_core] OK");
    end else begin
      $display("[impact_event_detector_core] ERROR");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+rtl
rtl/ied_pkg.sv
rtl/ied_if.sv
rtl/ied_mul.sv
rtl/ied_isqrt.sv
rtl/impact_event_detector_core.sv
sim/ied_scoreboard.sv
sim/tb.sv
